// ----- design/fpmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// fpmsr_pkg
// shared types and constants for the four-pad multitap serial reader
// ----------------------------------------------------------------------------
package fpmsr_pkg;

    localparam int unsigned NUM_PADS      = 4;
    localparam int unsigned BITS_PER_PAD  = 12;
    localparam int unsigned BUTTONS_W     = NUM_PADS * BITS_PER_PAD;
    localparam int unsigned COUNT_W       = 5;
    localparam int unsigned STEP_W        = 4;

    // counter milestones
    localparam logic [COUNT_W-1:0] COUNT_BUTTONS = 5'd12;
    localparam logic [COUNT_W-1:0] COUNT_DONE    = 5'd16;

    // fixed answers on the data line
    localparam logic [1:0] DETECT_CODE = 2'd2;
    localparam logic [1:0] DONE_CODE   = 2'd3;
    localparam logic [1:0] IDLE_CODE   = 2'd0;

    // button positions inside one pad word
    localparam int unsigned BTN_UP    = 4;
    localparam int unsigned BTN_DOWN  = 5;
    localparam int unsigned BTN_LEFT  = 6;
    localparam int unsigned BTN_RIGHT = 7;

    typedef enum logic
    {
        OP_LATCH = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef logic [BITS_PER_PAD-1:0] pad_word_t;

endpackage

// ----- design/fpmsr_pair_read.sv -----
// ----------------------------------------------------------------------------
// fpmsr_pair_read
// picks one button bit from each pad of the selected pair
// ----------------------------------------------------------------------------
module fpmsr_pair_read
    import fpmsr_pkg::*;
(
    input  logic [BUTTONS_W-1:0] buttons,
    input  logic                 io_select,
    input  logic [STEP_W-1:0]    step,
    output logic [1:0]           pair_data
);

    pad_word_t pad_first;
    pad_word_t pad_second;
    pad_word_t mask_first;
    pad_word_t mask_second;

    // io select high means pads 0/1, low means pads 2/3
    always_comb
    begin
        if (io_select)
        begin
            pad_first  = buttons[0*BITS_PER_PAD +: BITS_PER_PAD];
            pad_second = buttons[1*BITS_PER_PAD +: BITS_PER_PAD];
        end
        else
        begin
            pad_first  = buttons[2*BITS_PER_PAD +: BITS_PER_PAD];
            pad_second = buttons[3*BITS_PER_PAD +: BITS_PER_PAD];
        end
    end

    // opposite directions cancel each other
    always_comb
    begin
        mask_first             = pad_first;
        mask_first[BTN_UP]     = pad_first[BTN_UP]    & ~pad_first[BTN_DOWN];
        mask_first[BTN_DOWN]   = pad_first[BTN_DOWN]  & ~pad_first[BTN_UP];
        mask_first[BTN_LEFT]   = pad_first[BTN_LEFT]  & ~pad_first[BTN_RIGHT];
        mask_first[BTN_RIGHT]  = pad_first[BTN_RIGHT] & ~pad_first[BTN_LEFT];
        mask_second            = pad_second;
        mask_second[BTN_UP]    = pad_second[BTN_UP]    & ~pad_second[BTN_DOWN];
        mask_second[BTN_DOWN]  = pad_second[BTN_DOWN]  & ~pad_second[BTN_UP];
        mask_second[BTN_LEFT]  = pad_second[BTN_LEFT]  & ~pad_second[BTN_RIGHT];
        mask_second[BTN_RIGHT] = pad_second[BTN_RIGHT] & ~pad_second[BTN_LEFT];
    end

    always_comb
    begin
        if ({1'b0, step} < COUNT_BUTTONS)
        begin
            pair_data = {mask_second[step], mask_first[step]};
        end
        else
        begin
            pair_data = IDLE_CODE;
        end
    end

endmodule

// ----- design/four_pad_multitap_serial_reader.sv -----
// ----------------------------------------------------------------------------
// four_pad_multitap_serial_reader
// four-pad multitap behind one serial controller port
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one port access per transfer:
//   operation selects a latch line write or a data read. a latch write that
//   changes the level clears both pair counters, and a falling latch also
//   snapshots pad_buttons. a latch write gives no result.
//   output channel (out_valid/out_ready) returns read_data for every read.
// pipeline / throughput
//   an accepted item is held in the input register, then its result is
//   loaded into the output register, which drives read_data. one item per
//   cycle is sustained while the receiver keeps out_ready high, set by the
//   update of the latch/counter state in the work stage.
// reset
//   rst_n low clears the latch level, both counters, the captured buttons
//   and both valid flags.
// stalls
//   while out_ready is low and a result waits, a read in the input register
//   holds and in_ready drops; latch writes still pass since they give no
//   result.
// ----------------------------------------------------------------------------
module four_pad_multitap_serial_reader
    import fpmsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic                 latch_level,
    input  logic                 io_select,
    input  logic [BUTTONS_W-1:0] pad_buttons,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           read_data
);

    // input register
    logic                 s1_valid_reg;
    op_t                  s1_op_reg;
    logic                 s1_level_reg;
    logic                 s1_sel_reg;
    logic [BUTTONS_W-1:0] s1_buttons_reg;

    // block state
    logic                 latch_reg;
    logic                 latch_next;
    logic [COUNT_W-1:0]   count_one_reg;
    logic [COUNT_W-1:0]   count_one_next;
    logic [COUNT_W-1:0]   count_two_reg;
    logic [COUNT_W-1:0]   count_two_next;
    logic [BUTTONS_W-1:0] captured_reg;
    logic [BUTTONS_W-1:0] captured_next;

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           out_data_reg;
    logic [1:0]           out_data_next;

    logic                 s1_is_read;
    logic                 s1_fire;
    logic [COUNT_W-1:0]   count_sel;
    logic [1:0]           pair_data;

    assign s1_is_read = (s1_op_reg == OP_READ);

    // a read advances only when the output slot is free or draining
    assign s1_fire  = s1_valid_reg && (!s1_is_read || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign count_sel = s1_sel_reg ? count_one_reg : count_two_reg;

    fpmsr_pair_read u_pair_read
    (
        .buttons   (captured_reg),
        .io_select (s1_sel_reg),
        .step      (count_sel[STEP_W-1:0]),
        .pair_data (pair_data)
    );

    // work stage: state update and result for the item in the input register
    always_comb
    begin
        latch_next     = latch_reg;
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        captured_next  = captured_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (s1_fire)
        begin
            if (!s1_is_read)
            begin
                // only a level change has any effect
                if (s1_level_reg != latch_reg)
                begin
                    latch_next     = s1_level_reg;
                    count_one_next = '0;
                    count_two_next = '0;
                    if (!s1_level_reg)
                    begin
                        captured_next = s1_buttons_reg;
                    end
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                priority if (latch_reg)
                begin
                    // device detect while latched
                    out_data_next = DETECT_CODE;
                end
                else if (count_sel >= COUNT_DONE)
                begin
                    // counter saturated
                    out_data_next = DONE_CODE;
                end
                else
                begin
                    out_data_next = pair_data;
                    if (s1_sel_reg)
                    begin
                        count_one_next = count_one_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        count_two_next = count_two_reg + COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            latch_reg     <= 1'b0;
            count_one_reg <= '0;
            count_two_reg <= '0;
            captured_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            latch_reg     <= latch_next;
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
            captured_reg  <= captured_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg      <= op_t'(operation);
            s1_level_reg   <= latch_level;
            s1_sel_reg     <= io_select;
            s1_buttons_reg <= pad_buttons;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the four-pad multitap serial reader
// ----------------------------------------------------------------------------
// drives latch writes and data reads over the valid/ready input channel and
// checks every read_data transfer against an in-bench model of the latch
// level, both pair counters and the captured button snapshot. a directed
// opening covers the corner cases, then random latch/read sequences run
// under changing sender and receiver idling, with a long receiver hold-off
// and a sender pause that drains all pending reads
// ----------------------------------------------------------------------------
module tb;
    import fpmsr_pkg::*;

    // tracks the multitap state and queues the expected read answers
    class multitap_scoreboard;
        logic                 latched;
        logic [COUNT_W-1:0]   pair_one_step;
        logic [COUNT_W-1:0]   pair_two_step;
        logic [BUTTONS_W-1:0] snapshot;
        logic [1:0]           expected_reads[$];
        int unsigned          failures;
        int unsigned          reads_checked;
        int unsigned          detect_answers;
        int unsigned          done_answers;

        function new();
            latched        = 1'b0;
            pair_one_step  = '0;
            pair_two_step  = '0;
            snapshot       = '0;
            failures       = 0;
            reads_checked  = 0;
            detect_answers = 0;
            done_answers   = 0;
        endfunction

        // one pad's button at a counter step, opposite directions cancel
        function logic button_at(int unsigned pad, int unsigned step);
            pad_word_t word;
            logic      pressed;
            word    = snapshot[pad*BITS_PER_PAD +: BITS_PER_PAD];
            pressed = word[step];
            case (step)
                BTN_UP:    pressed = pressed & ~word[BTN_DOWN];
                BTN_DOWN:  pressed = pressed & ~word[BTN_UP];
                BTN_LEFT:  pressed = pressed & ~word[BTN_RIGHT];
                BTN_RIGHT: pressed = pressed & ~word[BTN_LEFT];
                default:   ;
            endcase
            return pressed;
        endfunction

        function void note_input(op_t op, logic level, logic sel,
                                 logic [BUTTONS_W-1:0] buttons);
            logic [COUNT_W-1:0] step;
            int unsigned        first_pad;
            logic [1:0]         answer;
            if (op == OP_LATCH)
            begin
                if (level != latched)
                begin
                    latched       = level;
                    pair_one_step = '0;
                    pair_two_step = '0;
                    if (!level)
                        snapshot = buttons;
                end
                return;
            end
            if (latched)
            begin
                answer = DETECT_CODE;
                detect_answers++;
            end
            else
            begin
                step      = sel ? pair_one_step : pair_two_step;
                first_pad = sel ? 0 : 2;
                if (step >= COUNT_DONE)
                begin
                    answer = DONE_CODE;
                    done_answers++;
                end
                else
                begin
                    if (sel)
                        pair_one_step = step + 1'b1;
                    else
                        pair_two_step = step + 1'b1;
                    if (step >= COUNT_BUTTONS)
                        answer = IDLE_CODE;
                    else
                        answer = {button_at(first_pad + 1, step), button_at(first_pad, step)};
                end
            end
            expected_reads.push_back(answer);
        endfunction

        function void check_result(logic [1:0] data);
            logic [1:0] want;
            if (expected_reads.size() == 0)
            begin
                $error("read_data: expected nothing, actual %0d", data);
                failures++;
                return;
            end
            want = expected_reads.pop_front();
            reads_checked++;
            if (data !== want)
            begin
                $error("read_data: expected %0d, actual %0d", want, data);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_reads.size();
        endfunction
    endclass

    localparam int unsigned RANDOM_ACCESSES = 1500;
    localparam int unsigned LONG_HOLD       = 300;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 operation   = OP_LATCH;
    logic                 latch_level = 1'b0;
    logic                 io_select   = 1'b0;
    logic [BUTTONS_W-1:0] pad_buttons = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [1:0]           read_data;

    multitap_scoreboard sb = new();

    // idle rates in percent, changed by the stimulus phases
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // long receiver hold-off, armed by the stimulus, counted by the receiver
    int unsigned rx_hold_request = 0;
    int unsigned rx_hold_left    = 0;
    int unsigned accesses_sent   = 0;

    four_pad_multitap_serial_reader dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .latch_level (latch_level),
        .io_select   (io_select),
        .pad_buttons (pad_buttons),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data)
    );

    always #5 clk = ~clk;

    // receiver side: random stalls, or a long hold-off when one is armed
    always @(negedge clk)
    begin
        if (rx_hold_request != 0)
        begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // every output transfer is checked at the edge it happens on
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(read_data);
    end

    // one input transfer: optional idle gap, then hold valid until accepted
    // called and returning at a falling edge
    task automatic send_access(op_t op, logic level, logic sel,
                               logic [BUTTONS_W-1:0] buttons);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        latch_level <= level;
        io_select   <= sel;
        pad_buttons <= buttons;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(op, level, sel, buttons);
        accesses_sent++;
        @(negedge clk);
    endtask

    function automatic logic [BUTTONS_W-1:0] random_word();
        logic [BUTTONS_W-1:0] word;
        word[31:0]          = $urandom();
        word[BUTTONS_W-1:32] = 16'($urandom());
        return word;
    endfunction

    // button snapshots of varied density so masking and idle pads both show
    function automatic logic [BUTTONS_W-1:0] random_buttons();
        case ($urandom_range(3))
            0:       return random_word();
            1:       return '1;
            2:       return random_word() & random_word() & random_word();
            default: return random_word() | random_word();
        endcase
    endfunction

    // io_select does nothing on a latch write, so it gets noise
    task automatic latch_write(logic level, logic [BUTTONS_W-1:0] buttons);
        send_access(OP_LATCH, level, 1'($urandom_range(1)), buttons);
    endtask

    // latch_level and pad_buttons do nothing on a read
    task automatic read_pair(logic sel);
        send_access(OP_READ, 1'($urandom_range(1)), sel, random_word());
    endtask

    task automatic drain_reads();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        bit          hold_done;
        bit          pause_done;
        int unsigned target;
        int unsigned guard;

        hold_done  = 0;
        pause_done = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed opening
        read_pair(1'b1);                  // fresh from reset, nothing captured
        latch_write(1'b0, '1);            // same level, no capture
        latch_write(1'b1, random_word()); // rising edge, buttons ignored
        read_pair(1'b1);                  // device detect while latched
        read_pair(1'b0);
        latch_write(1'b0, '1);            // falling edge, every button held
        // all steps of pair one: buttons, opposite directions masked,
        // trailing zeros, end marker and its saturation
        repeat (18) read_pair(1'b1);
        read_pair(1'b0);                  // pair two counter is independent

        target = accesses_sent + RANDOM_ACCESSES;
        while (accesses_sent < target)
        begin
            // idle profile per third of the random part
            if (target - accesses_sent > 2 * RANDOM_ACCESSES / 3)
            begin
                tx_idle_pct = 35;
                rx_idle_pct = 45;
            end
            else if (target - accesses_sent > RANDOM_ACCESSES / 3)
            begin
                tx_idle_pct = 45;
                rx_idle_pct = 35;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // receiver freezes while the sender keeps offering reads
            if (!hold_done && target - accesses_sent < RANDOM_ACCESSES / 2)
            begin
                rx_hold_request = LONG_HOLD;
                hold_done       = 1;
            end
            // sender stops until every read answer is back
            if (!pause_done && target - accesses_sent < RANDOM_ACCESSES / 4)
            begin
                drain_reads();
                pause_done = 1;
            end

            if ($urandom_range(9) < 7)
            begin
                // well-formed frame: latch, optional detect polls, capture,
                // then a burst of reads spread over both pairs
                latch_write(1'b1, random_word());
                repeat ($urandom_range(2)) read_pair(1'($urandom_range(1)));
                latch_write(1'b0, random_buttons());
                repeat ($urandom_range(36)) read_pair(1'($urandom_range(1)));
            end
            else
            begin
                // noise: arbitrary accesses, any field value
                repeat ($urandom_range(1, 6))
                    send_access(op_t'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), random_buttons());
            end
        end

        // wind down: everything answered, then a quiet pause
        in_valid <= 1'b0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        if (sb.outstanding() != 0)
        begin
            $error("read_data: %0d answers never arrived", sb.outstanding());
            sb.failures++;
        end

        $display("covered %0d port accesses with %0d reads checked", accesses_sent,
                 sb.reads_checked);
        $display("including %0d detect answers and %0d end-of-stream answers",
                 sb.detect_answers, sb.done_answers);
        if (sb.failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("tb failed");
        $finish;
    end

endmodule

// ----- four_pad_multitap_serial_reader.f -----
design/fpmsr_pkg.sv
design/fpmsr_pair_read.sv
design/four_pad_multitap_serial_reader.sv
tb/tb.sv
